@@ hdl/escd_pkg.sv @@
// ----------------------------------------------------------------------------
// escd_pkg
// Shared types and constants of the escape sequence decoder.
// ----------------------------------------------------------------------------
package escd_pkg;

  localparam int VALUE_WIDTH = 64;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_SP  = 8'h20;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_VT  = 8'h0B;
  localparam logic [7:0] CODE_NUL = 8'h00;

  localparam logic [3:0] HEX_LETTER_BIAS = 4'd9;

  typedef enum logic [2:0] {
    SEL_CODE,
    SEL_DEC,
    SEL_OCT,
    SEL_HEX,
    SEL_BAD
  } sel_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DEC,
    MODE_OCT,
    MODE_HEX
  } mode_t;

  typedef struct packed {
    logic       start;
    sel_t       sel;
    logic [7:0] code;
    logic       is_dec;
    logic       is_oct;
    logic       is_hex;
    logic [3:0] digit;
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hdl/escd_front.sv @@
// ----------------------------------------------------------------------------
// escd_front
// Classifies one character into a token: selector kind, control code and
// digit flags and weight for every radix.
// ----------------------------------------------------------------------------
module escd_front (
  input  logic              [7:0] ch,
  input  logic                    start_req,
  output escd_pkg::tok_t          tok
);

  logic is_dec;
  logic is_lower;
  logic is_upper;

  always_comb begin
    is_dec   = ch inside {[escd_pkg::CH_0 : escd_pkg::CH_9]};
    is_lower = ch inside {[escd_pkg::CH_LA : escd_pkg::CH_LF]};
    is_upper = ch inside {[escd_pkg::CH_UA : escd_pkg::CH_UF]};

    tok.start  = start_req;
    tok.is_dec = is_dec;
    tok.is_oct = ch inside {[escd_pkg::CH_0 : escd_pkg::CH_7]};
    tok.is_hex = is_dec | is_lower | is_upper;
    tok.digit  = is_dec ? ch[3:0] : ch[3:0] + escd_pkg::HEX_LETTER_BIAS;

    tok.sel  = escd_pkg::SEL_CODE;
    tok.code = escd_pkg::CODE_NUL;
    case (ch)
      escd_pkg::CH_B: tok.code = escd_pkg::CODE_BS;
      escd_pkg::CH_N: tok.code = escd_pkg::CODE_LF;
      escd_pkg::CH_R: tok.code = escd_pkg::CODE_CR;
      escd_pkg::CH_S: tok.code = escd_pkg::CODE_SP;
      escd_pkg::CH_T: tok.code = escd_pkg::CODE_TAB;
      escd_pkg::CH_V: tok.code = escd_pkg::CODE_VT;
      escd_pkg::CH_0: tok.code = escd_pkg::CODE_NUL;
      escd_pkg::CH_D: tok.sel  = escd_pkg::SEL_DEC;
      escd_pkg::CH_O: tok.sel  = escd_pkg::SEL_OCT;
      escd_pkg::CH_X: tok.sel  = escd_pkg::SEL_HEX;
      default:        tok.sel  = escd_pkg::SEL_BAD;
    endcase
  end

endmodule

@@ hdl/escd_queue.sv @@
// ----------------------------------------------------------------------------
// escd_queue
// Two-entry token queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module escd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  escd_pkg::tok_t      push_tok,
  input  logic                pop,
  output escd_pkg::tok_t      head_tok,
  output escd_pkg::q_stat_t   stat
);

  escd_pkg::tok_t mem_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  assign head_tok   = mem_r[rd_ptr_r];
  assign stat.full  = count_r[1];
  assign stat.empty = (count_r == 2'd0);

endmodule

@@ hdl/escd_back.sv @@
// ----------------------------------------------------------------------------
// escd_back
// Sequencer: run mode, accumulator fold and the output register.
// ----------------------------------------------------------------------------
module escd_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  escd_pkg::tok_t                        head_tok,
  input  logic                                  head_valid,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [escd_pkg::VALUE_WIDTH-1:0]      out_value,
  output logic                                  out_error,
  output logic                                  out_consumed
);

  localparam int W = escd_pkg::VALUE_WIDTH;

  escd_pkg::mode_t mode_r;
  escd_pkg::mode_t mode_nxt;
  logic [W-1:0]    accum_r;
  logic [W-1:0]    accum_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [W-1:0]    out_value_r;
  logic [W-1:0]    out_value_nxt;
  logic            out_error_r;
  logic            out_error_nxt;
  logic            out_consumed_r;
  logic            out_consumed_nxt;

  logic            room;
  logic            run_digit;
  logic            fold;
  logic            emit;

  assign room = !out_valid_r || !out_stall;
  assign pop  = head_valid && room;

  always_comb begin
    case (mode_r)
      escd_pkg::MODE_DEC: run_digit = head_tok.is_dec;
      escd_pkg::MODE_OCT: run_digit = head_tok.is_oct;
      escd_pkg::MODE_HEX: run_digit = head_tok.is_hex;
      default:            run_digit = 1'b0;
    endcase
    fold = (mode_r != escd_pkg::MODE_IDLE) && !head_tok.start && run_digit;
  end

  always_comb begin
    mode_nxt = mode_r;
    if (pop) begin
      if (mode_r != escd_pkg::MODE_IDLE) begin
        if (!fold) begin
          mode_nxt = escd_pkg::MODE_IDLE;
        end
      end else if (head_tok.start) begin
        case (head_tok.sel)
          escd_pkg::SEL_DEC: mode_nxt = escd_pkg::MODE_DEC;
          escd_pkg::SEL_OCT: mode_nxt = escd_pkg::MODE_OCT;
          escd_pkg::SEL_HEX: mode_nxt = escd_pkg::MODE_HEX;
          default:           mode_nxt = escd_pkg::MODE_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    accum_nxt        = accum_r;
    emit             = 1'b0;
    out_value_nxt    = out_value_r;
    out_error_nxt    = out_error_r;
    out_consumed_nxt = out_consumed_r;
    if (pop) begin
      if (mode_r != escd_pkg::MODE_IDLE) begin
        if (fold) begin
          case (mode_r)
            escd_pkg::MODE_DEC: accum_nxt = {accum_r[W-4:0], 3'b000}
                                          + {accum_r[W-2:0], 1'b0}
                                          + {{(W-4){1'b0}}, head_tok.digit};
            escd_pkg::MODE_OCT: accum_nxt = {accum_r[W-4:0], head_tok.digit[2:0]};
            default:            accum_nxt = {accum_r[W-5:0], head_tok.digit};
          endcase
        end else begin
          emit             = 1'b1;
          out_value_nxt    = accum_r;
          out_error_nxt    = 1'b0;
          out_consumed_nxt = 1'b0;
          accum_nxt        = '0;
        end
      end else if (head_tok.start) begin
        case (head_tok.sel)
          escd_pkg::SEL_CODE: begin
            emit             = 1'b1;
            out_value_nxt    = {{(W-8){1'b0}}, head_tok.code};
            out_error_nxt    = 1'b0;
            out_consumed_nxt = 1'b1;
          end
          escd_pkg::SEL_BAD: begin
            emit             = 1'b1;
            out_value_nxt    = '0;
            out_error_nxt    = 1'b1;
            out_consumed_nxt = 1'b0;
          end
          default: begin
            accum_nxt = '0;
          end
        endcase
      end
    end
    out_valid_nxt = room ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= escd_pkg::MODE_IDLE;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      accum_r     <= accum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r    <= out_value_nxt;
    out_error_r    <= out_error_nxt;
    out_consumed_r <= out_consumed_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_error    = out_error_r;
  assign out_consumed = out_consumed_r;

endmodule

@@ hdl/escape_sequence_decoder_top.sv @@
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top
// Escape sequence decoder: selector codes and decimal, octal, hex runs.
// ----------------------------------------------------------------------------
// Takes one character per cycle and sustains one per cycle while the result
// side does not stall: every character, digit or not, passes once through the
// sequencer, whose accumulator fold (shift-add by the run's radix) is the loop
// that sets the rate. A character is classified into the two-entry queue when
// it is accepted, then sequenced into the output register, where its result
// becomes valid.
// A run ends on the first non-digit or a new start: that result carries
// consumed low and the character must be sent again.
module escape_sequence_decoder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_ch,
  input  logic                               in_start_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [escd_pkg::VALUE_WIDTH-1:0]   out_value,
  output logic                               out_error,
  output logic                               out_consumed
);

  escd_pkg::tok_t    in_tok;
  escd_pkg::tok_t    head_tok;
  escd_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  escd_front u_front (
    .ch        (in_ch),
    .start_req (in_start_req),
    .tok       (in_tok)
  );

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  escd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (in_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .stat     (q_stat)
  );

  escd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_tok     (head_tok),
    .head_valid   (!q_stat.empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_error    (out_error),
    .out_consumed (out_consumed)
  );

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_consumed && (out_value == '0))
    else $error("error result must be unconsumed with value zero");

  a_code_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_consumed |-> !out_error
      && (out_value[escd_pkg::VALUE_WIDTH-1:8] == '0))
    else $error("consumed result must be an 8-bit control code");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && q_stat.empty)
    else $error("block not idle after reset");

endmodule

@@ test/escape_sequence_decoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top_tb
// Self-checking testbench for the escape sequence decoder.
// ----------------------------------------------------------------------------
// Directed tests walk every control-code selector, unknown selectors, ignored
// characters, decimal/octal/hex runs, empty runs and runs closed by a new
// start. A backpressure test holds the result side off until the block stalls
// its input. Random streams of well-formed sequences mixed with noise follow,
// first with no idling, then with random gaps on both sides. A predictor
// follows every accepted transaction and each result is compared field by
// field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          DRAIN_LIMIT  = 5000;
  localparam logic [63:0] RADIX_DEC    = 64'd10;
  localparam logic [63:0] RADIX_OCT    = 64'd8;
  localparam logic [63:0] RADIX_HEX    = 64'd16;

  typedef struct packed {
    logic [63:0] value;
    logic        error;
    logic        consumed;
  } esc_result_t;

  logic                             clk          = 1'b0;
  logic                             rst_n        = 1'b0;
  logic                             in_valid     = 1'b0;
  logic                             in_stall;
  logic [7:0]                       in_ch        = 8'h00;
  logic                             in_start_req = 1'b0;
  logic                             out_valid;
  logic                             out_stall    = 1'b0;
  logic [escd_pkg::VALUE_WIDTH-1:0] out_value;
  logic                             out_error;
  logic                             out_consumed;

  esc_result_t     pending_results[$];
  escd_pkg::mode_t run_mode      = escd_pkg::MODE_IDLE;
  logic [63:0]     run_accum     = '0;
  int              live_items    = 0;
  int              mismatches    = 0;
  bit              sender_gaps   = 1'b1;
  bit              receiver_gaps = 1'b1;
  bit              hold_req      = 1'b0;

  escape_sequence_decoder_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_error    (out_error),
    .out_consumed (out_consumed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("escape_sequence_decoder_top verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, wanted, $realtime);
    mismatches++;
  endtask

  function automatic int digit_weight(input escd_pkg::mode_t m, input logic [7:0] ch);
    int weight;
    weight = -1;
    case (m)
      escd_pkg::MODE_DEC:
        if (ch >= escd_pkg::CH_0 && ch <= escd_pkg::CH_9) weight = int'(ch - escd_pkg::CH_0);
      escd_pkg::MODE_OCT:
        if (ch >= escd_pkg::CH_0 && ch <= escd_pkg::CH_7) weight = int'(ch - escd_pkg::CH_0);
      escd_pkg::MODE_HEX: begin
        if (ch >= escd_pkg::CH_0 && ch <= escd_pkg::CH_9)
          weight = int'(ch - escd_pkg::CH_0);
        else if (ch >= escd_pkg::CH_LA && ch <= escd_pkg::CH_LF)
          weight = int'(ch - escd_pkg::CH_LA) + 10;
        else if (ch >= escd_pkg::CH_UA && ch <= escd_pkg::CH_UF)
          weight = int'(ch - escd_pkg::CH_UA) + 10;
      end
      default: weight = -1;
    endcase
    return weight;
  endfunction

  task automatic push_result(input logic [63:0] value, input logic err,
                             input logic cons);
    esc_result_t r;
    r.value    = value;
    r.error    = err;
    r.consumed = cons;
    pending_results.push_back(r);
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic st);
    int          weight;
    logic [63:0] radix;
    if (run_mode != escd_pkg::MODE_IDLE) begin
      live_items++;
      weight = digit_weight(run_mode, ch);
      if (!st && weight >= 0) begin
        case (run_mode)
          escd_pkg::MODE_DEC: radix = RADIX_DEC;
          escd_pkg::MODE_OCT: radix = RADIX_OCT;
          default:            radix = RADIX_HEX;
        endcase
        run_accum = run_accum * radix + 64'(weight);
      end else begin
        push_result(run_accum, 1'b0, 1'b0);
        run_mode  = escd_pkg::MODE_IDLE;
        run_accum = '0;
      end
    end else if (st) begin
      live_items++;
      case (ch)
        escd_pkg::CH_B: push_result(64'(escd_pkg::CODE_BS), 1'b0, 1'b1);
        escd_pkg::CH_N: push_result(64'(escd_pkg::CODE_LF), 1'b0, 1'b1);
        escd_pkg::CH_R: push_result(64'(escd_pkg::CODE_CR), 1'b0, 1'b1);
        escd_pkg::CH_S: push_result(64'(escd_pkg::CODE_SP), 1'b0, 1'b1);
        escd_pkg::CH_T: push_result(64'(escd_pkg::CODE_TAB), 1'b0, 1'b1);
        escd_pkg::CH_V: push_result(64'(escd_pkg::CODE_VT), 1'b0, 1'b1);
        escd_pkg::CH_0: push_result(64'(escd_pkg::CODE_NUL), 1'b0, 1'b1);
        escd_pkg::CH_D: begin
          run_mode  = escd_pkg::MODE_DEC;
          run_accum = '0;
        end
        escd_pkg::CH_O: begin
          run_mode  = escd_pkg::MODE_OCT;
          run_accum = '0;
        end
        escd_pkg::CH_X: begin
          run_mode  = escd_pkg::MODE_HEX;
          run_accum = '0;
        end
        default: push_result(64'd0, 1'b1, 1'b0);
      endcase
    end
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(5, 25));
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic st);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid     = 1'b0;
      in_ch        = 8'($urandom_range(0, 255));
      in_start_req = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_ch        = ch;
    in_start_req = st;
    do @(posedge clk); while (in_stall);
    decode_char(ch, st);
  endtask

  // a start that closes an open run is handed back and sent again
  task automatic open_sequence(input logic [7:0] sel);
    bit was_open;
    was_open = (run_mode != escd_pkg::MODE_IDLE);
    send_char(sel, 1'b1);
    if (was_open) send_char(sel, 1'b1);
  endtask

  task automatic send_run(input escd_pkg::mode_t m);
    logic [7:0]  ch;
    int          len;
    int unsigned r;
    int unsigned k;
    case (m)
      escd_pkg::MODE_DEC: open_sequence(escd_pkg::CH_D);
      escd_pkg::MODE_OCT: open_sequence(escd_pkg::CH_O);
      default:            open_sequence(escd_pkg::CH_X);
    endcase
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 88) len = int'($urandom_range(1, 6));
    else len = int'($urandom_range(15, 26));
    repeat (len) begin
      case (m)
        escd_pkg::MODE_DEC: ch = escd_pkg::CH_0 + 8'($urandom_range(0, 9));
        escd_pkg::MODE_OCT: ch = escd_pkg::CH_0 + 8'($urandom_range(0, 7));
        default: begin
          k = $urandom_range(0, 21);
          if (k < 10) ch = escd_pkg::CH_0 + 8'(k);
          else if (k < 16) ch = escd_pkg::CH_LA + 8'(k - 10);
          else ch = escd_pkg::CH_UA + 8'(k - 16);
        end
      endcase
      send_char(ch, 1'b0);
    end
    r = $urandom_range(0, 2);
    if (r != 0) begin
      do ch = 8'($urandom_range(0, 255)); while (digit_weight(m, ch) >= 0);
      send_char(ch, 1'b0);
      if (r == 2) send_char(ch, 1'b0);
    end
  endtask

  task automatic wait_drained();
    int cycles;
    cycles = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", 64'(pending_results.size()), 64'd0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_selector_codes();
    send_char(escd_pkg::CH_B, 1'b1);
    send_char(escd_pkg::CH_N, 1'b1);
    send_char(escd_pkg::CH_R, 1'b1);
    send_char(escd_pkg::CH_S, 1'b1);
    send_char(escd_pkg::CH_T, 1'b1);
    send_char(escd_pkg::CH_V, 1'b1);
    send_char(escd_pkg::CH_0, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(escd_pkg::CH_N, 1'b0);
  endtask

  task automatic test_number_runs();
    send_char(escd_pkg::CH_D, 1'b1);
    send_char(escd_pkg::CH_9, 1'b0);
    send_char(escd_pkg::CH_0 + 8'd5, 1'b0);
    send_char(escd_pkg::CH_0 - 8'd1, 1'b0);
    send_char(escd_pkg::CH_O, 1'b1);
    send_char(escd_pkg::CH_7, 1'b0);
    send_char(escd_pkg::CH_9 - 8'd1, 1'b0);
    send_char(escd_pkg::CH_X, 1'b1);
    send_char(escd_pkg::CH_UF, 1'b0);
    send_char(escd_pkg::CH_LA, 1'b0);
    send_char(escd_pkg::CH_UF + 8'd1, 1'b0);
    send_char(escd_pkg::CH_X, 1'b1);
    send_char(escd_pkg::CH_D, 1'b1);
    send_char(escd_pkg::CH_D, 1'b1);
    send_char(escd_pkg::CH_9 + 8'd1, 1'b0);
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    repeat (40) send_char(escd_pkg::CH_N, 1'b1);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_stream(input int count, input bit gaps);
    int          target;
    int unsigned r;
    sender_gaps   = gaps;
    receiver_gaps = gaps;
    target = live_items + count;
    while (live_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        case ($urandom_range(0, 2))
          0:       send_run(escd_pkg::MODE_DEC);
          1:       send_run(escd_pkg::MODE_OCT);
          default: send_run(escd_pkg::MODE_HEX);
        endcase
      end else if (r < 75) begin
        case ($urandom_range(0, 7))
          0:       open_sequence(escd_pkg::CH_B);
          1:       open_sequence(escd_pkg::CH_N);
          2:       open_sequence(escd_pkg::CH_R);
          3:       open_sequence(escd_pkg::CH_S);
          4:       open_sequence(escd_pkg::CH_T);
          5:       open_sequence(escd_pkg::CH_V);
          6:       open_sequence(escd_pkg::CH_0);
          default: open_sequence(8'($urandom_range(0, 255)));
        endcase
      end else begin
        repeat ($urandom_range(1, 4))
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  initial begin
    int          left;
    int unsigned r;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else if (left > 0) begin
        out_stall = 1'b1;
        left--;
      end else if (!receiver_gaps) begin
        out_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          out_stall = 1'b0;
        end else begin
          out_stall = 1'b1;
          left = (r < 92) ? int'($urandom_range(0, 2)) : int'($urandom_range(5, 30));
        end
      end
    end
  end

  always @(posedge clk) begin
    esc_result_t wanted;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_value, 64'd0);
      end else begin
        wanted = pending_results.pop_front();
        if (out_value !== wanted.value)
          report_mismatch("value", out_value, wanted.value);
        if (out_error !== wanted.error)
          report_mismatch("error", 64'(out_error), 64'(wanted.error));
        if (out_consumed !== wanted.consumed)
          report_mismatch("consumed", 64'(out_consumed), 64'(wanted.consumed));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_selector_codes();
    test_number_runs();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_stream(300, 1'b0);
    test_random_stream(1200, 1'b1);
    wait_drained();

    if (mismatches == 0) begin
      $display("escape_sequence_decoder_top verification clean");
    end else begin
      $display("escape_sequence_decoder_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/escd_pkg.sv
hdl/escd_front.sv
hdl/escd_queue.sv
hdl/escd_back.sv
hdl/escape_sequence_decoder_top.sv
test/escape_sequence_decoder_top_tb.sv
